[design/acrs_pkg.sv]
// Shared types and constants of the ATA task-file command sequencer.
// No dependencies; used by acrs_emitter and ata_command_register_sequencer.
`timescale 1ns / 1ps

package acrs_pkg;

	localparam int LBA28_W = 28;

	// configuration register indexes
	localparam logic [1:0] REG_DEVICE_PRESENT = 2'd0;
	localparam logic [1:0] REG_LBA_CAPABLE    = 2'd1;
	localparam logic [1:0] REG_DRIVE_SLAVE    = 2'd2;
	localparam logic [1:0] REG_CAPACITY       = 2'd3;

	// result status codes
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_NO_DEV = 2'd1;
	localparam logic [1:0] STS_RANGE  = 2'd2;

	// port blocks and offsets
	localparam logic       BLK_CMD   = 1'b0;
	localparam logic       BLK_CTRL  = 1'b1;
	localparam logic [2:0] OFS_CTRL  = 3'd2;
	localparam logic [2:0] OFS_COUNT = 3'd2;
	localparam logic [2:0] OFS_LBA0  = 3'd3;
	localparam logic [2:0] OFS_LBA1  = 3'd4;
	localparam logic [2:0] OFS_LBA2  = 3'd5;
	localparam logic [2:0] OFS_SEL   = 3'd6;
	localparam logic [2:0] OFS_CMD   = 3'd7;

	// register values
	localparam logic [7:0] CTRL_NIEN    = 8'h02;
	localparam logic [7:0] CTRL_HOB     = 8'h80;
	localparam logic [7:0] SEL_LBA      = 8'hE0;
	localparam logic [7:0] SEL_CHS      = 8'hA0;
	localparam logic [7:0] OPC_READ     = 8'h20;
	localparam logic [7:0] OPC_WRITE    = 8'h30;
	localparam logic [7:0] OPC_EXT_FLAG = 8'h04;

	// one-hot, in emission order
	typedef enum logic [18:0] {
		ST_CTRL      = 19'h00001,
		ST_SEL       = 19'h00002,
		ST_HOB_ON0   = 19'h00004,
		ST_HOB_CNT   = 19'h00008,
		ST_HOB_OFF0  = 19'h00010,
		ST_HOB_ON1   = 19'h00020,
		ST_HOB_LBA0  = 19'h00040,
		ST_HOB_OFF1  = 19'h00080,
		ST_HOB_ON2   = 19'h00100,
		ST_HOB_LBA1  = 19'h00200,
		ST_HOB_OFF2  = 19'h00400,
		ST_HOB_ON3   = 19'h00800,
		ST_HOB_LBA2  = 19'h01000,
		ST_HOB_OFF3  = 19'h02000,
		ST_CNT       = 19'h04000,
		ST_LBA0      = 19'h08000,
		ST_LBA1      = 19'h10000,
		ST_LBA2      = 19'h20000,
		ST_CMD       = 19'h40000
	} step_t;

	// fully resolved command, handed to the emitter
	typedef struct packed {
		logic [1:0] status;
		logic       ext;
		logic [7:0] sel;
		logic [7:0] hob;
		logic [7:0] count;
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] a2;
		logic [7:0] opcode;
	} acrs_cmd_t;

	typedef struct packed {
		logic       port_block;
		logic [2:0] port_offset;
		logic [7:0] write_data;
		logic [1:0] status;
		logic       last;
	} acrs_result_t;

endpackage

[design/acrs_emitter.sv]
// Walks one resolved command through its task-file writes, one per cycle.
// Depends on acrs_pkg.
`timescale 1ns / 1ps

module acrs_emitter
	import acrs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  acrs_cmd_t    cmd,
	output logic         free,
	output logic         strobe,
	output acrs_result_t result
);

	logic         active_q;
	step_t        step_q;
	step_t        step_nxt;
	acrs_cmd_t    cmd_q;
	acrs_result_t res_d;
	acrs_result_t res_q;
	logic         strobe_q;

	always_comb begin
		res_d = '0;
		res_d.status = cmd_q.status;
		if (cmd_q.status != STS_OK) begin
			res_d.last = 1'b1;
		end else begin
			unique case (step_q)
				ST_CTRL: begin
					res_d.port_block = BLK_CTRL;
					res_d.port_offset = OFS_CTRL;
					res_d.write_data = CTRL_NIEN;
				end
				ST_SEL: begin
					res_d.port_offset = OFS_SEL;
					res_d.write_data = cmd_q.sel;
				end
				ST_HOB_ON0, ST_HOB_ON1, ST_HOB_ON2, ST_HOB_ON3: begin
					res_d.port_block = BLK_CTRL;
					res_d.port_offset = OFS_CTRL;
					res_d.write_data = CTRL_HOB | CTRL_NIEN;
				end
				ST_HOB_OFF0, ST_HOB_OFF1, ST_HOB_OFF2, ST_HOB_OFF3: begin
					res_d.port_block = BLK_CTRL;
					res_d.port_offset = OFS_CTRL;
					res_d.write_data = CTRL_NIEN;
				end
				ST_HOB_CNT: res_d.port_offset = OFS_COUNT;
				ST_HOB_LBA0: begin
					res_d.port_offset = OFS_LBA0;
					res_d.write_data = cmd_q.hob;
				end
				ST_HOB_LBA1: res_d.port_offset = OFS_LBA1;
				ST_HOB_LBA2: res_d.port_offset = OFS_LBA2;
				ST_CNT: begin
					res_d.port_offset = OFS_COUNT;
					res_d.write_data = cmd_q.count;
				end
				ST_LBA0: begin
					res_d.port_offset = OFS_LBA0;
					res_d.write_data = cmd_q.a0;
				end
				ST_LBA1: begin
					res_d.port_offset = OFS_LBA1;
					res_d.write_data = cmd_q.a1;
				end
				ST_LBA2: begin
					res_d.port_offset = OFS_LBA2;
					res_d.write_data = cmd_q.a2;
				end
				ST_CMD: begin
					res_d.port_offset = OFS_CMD;
					res_d.write_data = cmd_q.opcode;
					res_d.last = 1'b1;
				end
				default: res_d.last = 1'b1;
			endcase
		end
	end

	always_comb begin
		if (step_q == ST_SEL && !cmd_q.ext) begin
			step_nxt = ST_CNT;
		end else begin
			step_nxt = step_t'(step_q << 1);
		end
	end

	assign free = !active_q || res_d.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q <= ST_CTRL;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				step_q <= ST_CTRL;
			end else if (active_q) begin
				if (res_d.last) begin
					active_q <= 1'b0;
				end else begin
					step_q <= step_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd;
		end
		res_q <= res_d;
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

[design/ata_command_register_sequencer.sv]
// Top level of the ATA PIO task-file command sequencer: config registers,
// checks, address resolution pipeline. Depends on acrs_pkg, acrs_emitter.
//
// channel   signals                               transaction when
// request   start/busy, op, lba, sector_count     start && !busy
// config    cfg_valid/cfg_ready, cfg_index/data   cfg_valid && cfg_ready
// result    strobe, port_block .. last            strobe (no backpressure)
//
// A request passes through the resolve stages and the emitter's output register
// before its first result is on the ports. Results then leave one per cycle:
// 1 on an error, 7 for LBA28/CHS, 19 for LBA48. The emitter sets the rate; a
// queued request's results follow with no gap. busy rises while the input
// stage holds a request the pipeline can't take yet. Reset clears the pipeline
// and loads the config defaults.
`timescale 1ns / 1ps

module ata_command_register_sequencer
	import acrs_pkg::*;
#(
	parameter int SECTORS_PER_TRACK = 63,
	parameter int HEADS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] lba,
	input  logic [7:0]  sector_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        strobe,
	output logic        port_block,
	output logic [2:0]  port_offset,
	output logic [7:0]  write_data,
	output logic [1:0]  status,
	output logic        last
);

	localparam int LW = LBA28_W;
	localparam int RW = LW + 1;
	localparam int CYL = SECTORS_PER_TRACK * HEADS;
	localparam int SPT_W = $clog2(SECTORS_PER_TRACK + 1);
	localparam logic [RW-1:0] R_SPT = RW'((64'd1 << LW) / 64'(SECTORS_PER_TRACK));
	localparam logic [RW-1:0] R_CYL = RW'((64'd1 << LW) / 64'(CYL));

	logic        device_present_q;
	logic        lba_capable_q;
	logic        drive_slave_q;
	logic [31:0] capacity_q;

	logic        v_s1, v_s2, v_s3;
	logic        op_s1, op_s2, op_s3;
	logic [31:0] lba_s1, lba_s2, lba_s3;
	logic [7:0]  cnt_s1, cnt_s2, cnt_s3;
	logic [1:0]  status_s2, status_s3;
	logic        ext_s2, ext_s3;
	logic        chs_s2, chs_s3;
	logic [LW-1:0] q0spt_s2, q0cyl_s2;
	logic [SPT_W-1:0] sect_s3;
	logic [15:0] cyl_s3;
	logic [3:0]  qspt_lo_s3, qcyl_lo_s3;

	logic        accept, adv1, adv2, load, free;
	logic [1:0]  status_c;
	logic        ext_c;
	logic [LW+RW-1:0] p_spt, p_cyl;
	logic [LW-1:0] r_spt_full, r_cyl_full;
	logic        ge_spt, ge_cyl;
	logic [LW-1:0] q_spt, q_cyl;
	logic [SPT_W-1:0] r_spt;
	logic [3:0]  head_chs, head;
	acrs_cmd_t   cmd;
	acrs_result_t res;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_present_q <= 1'b0;
			lba_capable_q <= 1'b1;
			drive_slave_q <= 1'b0;
			capacity_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEVICE_PRESENT: device_present_q <= cfg_data[0];
				REG_LBA_CAPABLE:    lba_capable_q <= cfg_data[0];
				REG_DRIVE_SLAVE:    drive_slave_q <= cfg_data[0];
				REG_CAPACITY:       capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow
	assign load = v_s3 && free;
	assign adv2 = v_s2 && (!v_s3 || load);
	assign adv1 = v_s1 && (!v_s2 || adv2);
	assign busy = v_s1 && !adv1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (accept) v_s1 <= 1'b1;
			else if (adv1) v_s1 <= 1'b0;
			if (adv1) v_s2 <= 1'b1;
			else if (adv2) v_s2 <= 1'b0;
			if (adv2) v_s3 <= 1'b1;
			else if (load) v_s3 <= 1'b0;
		end
	end

	// stage 1: checks, mode, reciprocal products
	always_comb begin
		if (!device_present_q) begin
			status_c = STS_NO_DEV;
		end else if (({1'b0, lba_s1} + 33'(cnt_s1)) > {1'b0, capacity_q}) begin
			status_c = STS_RANGE;
		end else begin
			status_c = STS_OK;
		end
	end

	assign ext_c = lba_s1[31:LW] != '0;
	assign p_spt = (LW+RW)'(lba_s1[LW-1:0]) * (LW+RW)'(R_SPT);
	assign p_cyl = (LW+RW)'(lba_s1[LW-1:0]) * (LW+RW)'(R_CYL);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			lba_s1 <= lba;
			cnt_s1 <= sector_count;
		end
		if (adv1) begin
			op_s2 <= op_s1;
			lba_s2 <= lba_s1;
			cnt_s2 <= cnt_s1;
			status_s2 <= status_c;
			ext_s2 <= ext_c;
			chs_s2 <= !ext_c && !lba_capable_q;
			q0spt_s2 <= p_spt[2*LW-1:LW];
			q0cyl_s2 <= p_cyl[2*LW-1:LW];
		end
		if (adv2) begin
			op_s3 <= op_s2;
			lba_s3 <= lba_s2;
			cnt_s3 <= cnt_s2;
			status_s3 <= status_s2;
			ext_s3 <= ext_s2;
			chs_s3 <= chs_s2;
			sect_s3 <= SPT_W'(r_spt + SPT_W'(1));
			cyl_s3 <= q_cyl[15:0];
			qspt_lo_s3 <= q_spt[3:0];
			qcyl_lo_s3 <= q_cyl[3:0];
		end
	end

	// stage 2: quotient correction
	assign r_spt_full = lba_s2[LW-1:0] - LW'(q0spt_s2 * LW'(SECTORS_PER_TRACK));
	assign r_cyl_full = lba_s2[LW-1:0] - LW'(q0cyl_s2 * LW'(CYL));
	assign ge_spt = r_spt_full >= LW'(SECTORS_PER_TRACK);
	assign ge_cyl = r_cyl_full >= LW'(CYL);
	assign q_spt = q0spt_s2 + LW'(ge_spt);
	assign q_cyl = q0cyl_s2 + LW'(ge_cyl);
	assign r_spt = ge_spt ? SPT_W'(r_spt_full - LW'(SECTORS_PER_TRACK))
	                      : SPT_W'(r_spt_full);

	// stage 3: assemble the command
	assign head_chs = 4'(qspt_lo_s3 - 4'(qcyl_lo_s3 * 4'(HEADS)));

	always_comb begin
		if (ext_s3) head = 4'd0;
		else if (chs_s3) head = head_chs;
		else head = lba_s3[27:24];
	end

	always_comb begin
		cmd.status = status_s3;
		cmd.ext = ext_s3;
		cmd.sel = (chs_s3 ? SEL_CHS : SEL_LBA) | {3'd0, drive_slave_q, head};
		cmd.hob = lba_s3[31:24];
		cmd.count = cnt_s3;
		cmd.a0 = chs_s3 ? 8'(sect_s3) : lba_s3[7:0];
		cmd.a1 = chs_s3 ? cyl_s3[7:0] : lba_s3[15:8];
		cmd.a2 = chs_s3 ? cyl_s3[15:8] : lba_s3[23:16];
		cmd.opcode = (op_s3 ? OPC_WRITE : OPC_READ) | (ext_s3 ? OPC_EXT_FLAG : 8'h00);
	end

	acrs_emitter u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.cmd    (cmd),
		.free   (free),
		.strobe (strobe),
		.result (res)
	);

	assign port_block = res.port_block;
	assign port_offset = res.port_offset;
	assign write_data = res.write_data;
	assign status = res.status;
	assign last = res.last;

endmodule
